// ===== sv/ubxp_pkg.sv =====
// ----------------------------------------------------------------------------
// UBX parser package
// Shared types, codes and constants of the UBX frame parser.
// ----------------------------------------------------------------------------
package ubxp_pkg;

    localparam int OFFSET_W = 17;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    localparam logic [OFFSET_W-1:0] HEADER_BYTES    = 17'd6;
    localparam logic [OFFSET_W-1:0] OVERHEAD_BYTES  = 17'd8;
    localparam logic [OFFSET_W-1:0] LEN_LOW_OFFSET  = 17'd4;
    localparam logic [OFFSET_W-1:0] LEN_HIGH_OFFSET = 17'd5;
    localparam logic [OFFSET_W-1:0] MAX_FRAME_RESET = 17'd256;

    // Word index of the frame size limit register.
    localparam logic REG_MAX_FRAME = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_BODY  = 2'd2,
        PH_CKB   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_DISCARD  = 3'd0,
        EV_SYNC     = 3'd1,
        EV_BODY     = 3'd2,
        EV_CKA      = 3'd3,
        EV_OK       = 3'd4,
        EV_BAD_CK   = 3'd5,
        EV_TOO_LONG = 3'd6,
        EV_RESET    = 3'd7
    } event_t;

    // How the back end derives the remaining byte count.
    typedef enum logic [1:0] {
        WANT_ONE    = 2'd0,
        WANT_HEADER = 2'd1,
        WANT_FRAME  = 2'd2
    } want_sel_t;

    typedef struct packed {
        event_t                event_code;
        logic [7:0]            data;
        logic [OFFSET_W-1:0]   offset;
        logic [OFFSET_W-1:0]   frame_len;
        want_sel_t             want_sel;
    } rec_t;

endpackage

// ===== sv/ubxp_front.sv =====
// ----------------------------------------------------------------------------
// UBX parser front end
// Accepts one byte per beat, tracks the frame state and classifies the byte.
// ----------------------------------------------------------------------------
module ubxp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          mode,
    input  logic [7:0]                    data_byte,
    input  logic [ubxp_pkg::OFFSET_W-1:0] max_frame,
    output ubxp_pkg::rec_t                rec
);
    import ubxp_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [OFFSET_W-1:0] count_reg, count_next;
    logic [7:0]          len_low_reg, len_low_next;
    logic [OFFSET_W-1:0] frame_len_reg, frame_len_next;
    logic [7:0]          sum_a_reg, sum_a_next;
    logic [7:0]          sum_b_reg, sum_b_next;
    logic                cka_ok_reg, cka_ok_next;

    logic [7:0]          sum_a_add;
    logic [7:0]          sum_b_add;
    logic [OFFSET_W-1:0] new_len;
    logic [OFFSET_W-1:0] off_inc;
    logic                is_cka;
    logic                too_long;

    assign sum_a_add = sum_a_reg + data_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign new_len   = {1'b0, data_byte, len_low_reg} + OVERHEAD_BYTES;
    assign off_inc   = count_reg + 17'd1;
    assign is_cka    = (count_reg >= HEADER_BYTES)
                     && (({1'b0, count_reg} + 18'd2) == {1'b0, frame_len_reg});
    assign too_long  = new_len > max_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            len_low_reg   <= '0;
            frame_len_reg <= '0;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            cka_ok_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            len_low_reg   <= len_low_next;
            frame_len_reg <= frame_len_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            cka_ok_reg    <= cka_ok_next;
        end
    end

    // Next state of the parser.
    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        len_low_next   = len_low_reg;
        frame_len_next = frame_len_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        cka_ok_next    = cka_ok_reg;
        if (mode)
        begin
            phase_next = PH_HUNT;
            count_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == SYNC_ONE)
                    begin
                        phase_next = PH_SYNC2;
                        count_next = 17'd1;
                    end
                end
                PH_SYNC2:
                begin
                    if (data_byte == SYNC_TWO)
                    begin
                        phase_next = PH_BODY;
                        count_next = 17'd2;
                        sum_a_next = '0;
                        sum_b_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                    end
                end
                PH_BODY:
                begin
                    if (is_cka)
                    begin
                        cka_ok_next = (data_byte == sum_a_reg);
                        phase_next  = PH_CKB;
                        count_next  = off_inc;
                    end
                    else
                    begin
                        sum_a_next = sum_a_add;
                        sum_b_next = sum_b_add;
                        count_next = off_inc;
                        if (count_reg == LEN_LOW_OFFSET)
                        begin
                            len_low_next = data_byte;
                        end
                        if (count_reg == LEN_HIGH_OFFSET)
                        begin
                            frame_len_next = new_len;
                            if (too_long)
                            begin
                                phase_next = PH_HUNT;
                                count_next = '0;
                            end
                        end
                    end
                end
                PH_CKB:
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    // Classification of the current byte.
    always_comb
    begin
        rec.event_code = EV_DISCARD;
        rec.data       = data_byte;
        rec.offset     = '0;
        rec.frame_len  = frame_len_reg;
        rec.want_sel   = WANT_ONE;
        if (mode)
        begin
            rec.event_code = EV_RESET;
            rec.data       = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == SYNC_ONE)
                    begin
                        rec.event_code = EV_SYNC;
                        rec.want_sel   = WANT_HEADER;
                    end
                end
                PH_SYNC2:
                begin
                    if (data_byte == SYNC_TWO)
                    begin
                        rec.event_code = EV_SYNC;
                        rec.offset     = 17'd1;
                        rec.want_sel   = WANT_HEADER;
                    end
                end
                PH_BODY:
                begin
                    rec.offset = count_reg;
                    if (is_cka)
                    begin
                        rec.event_code = EV_CKA;
                    end
                    else if (count_reg == LEN_HIGH_OFFSET)
                    begin
                        rec.frame_len = new_len;
                        if (too_long)
                        begin
                            rec.event_code = EV_TOO_LONG;
                        end
                        else
                        begin
                            rec.event_code = EV_BODY;
                            rec.want_sel   = WANT_FRAME;
                        end
                    end
                    else if (count_reg < HEADER_BYTES)
                    begin
                        rec.event_code = EV_BODY;
                        rec.want_sel   = WANT_HEADER;
                    end
                    else
                    begin
                        rec.event_code = EV_BODY;
                        rec.want_sel   = WANT_FRAME;
                    end
                end
                PH_CKB:
                begin
                    rec.offset = count_reg;
                    if (cka_ok_reg && (data_byte == sum_b_reg))
                    begin
                        rec.event_code = EV_OK;
                    end
                    else
                    begin
                        rec.event_code = EV_BAD_CK;
                    end
                end
                default:
                begin
                    rec.event_code = EV_DISCARD;
                end
            endcase
        end
    end

endmodule

// ===== sv/ubxp_queue.sv =====
// ----------------------------------------------------------------------------
// UBX parser queue
// Small first-in first-out buffer of classified bytes between the two ends.
// ----------------------------------------------------------------------------
module ubxp_queue #(
    parameter int DEPTH = ubxp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ubxp_pkg::rec_t wr_rec,
    input  logic           pop,
    output ubxp_pkg::rec_t rd_rec,
    output logic           not_empty,
    output logic           full
);
    import ubxp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign rd_rec    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

// ===== sv/ubxp_back.sv =====
// ----------------------------------------------------------------------------
// UBX parser back end
// Derives the remaining byte count and holds the result beat until taken.
// ----------------------------------------------------------------------------
module ubxp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ubxp_pkg::rec_t                rec,
    input  logic                          rec_valid,
    output logic                          rec_pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [2:0]                    event_res,
    output logic [7:0]                    byte_out,
    output logic [ubxp_pkg::OFFSET_W-1:0] frame_offset,
    output logic [ubxp_pkg::OFFSET_W-1:0] bytes_wanted
);
    import ubxp_pkg::*;

    logic                valid_reg;
    event_t              event_reg;
    logic [7:0]          byte_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] want_reg;
    logic [OFFSET_W-1:0] want_next;
    logic [OFFSET_W-1:0] off_inc;

    assign rec_pop = rec_valid && (!valid_reg || result_ready);
    assign off_inc = rec.offset + 17'd1;

    always_comb
    begin
        case (rec.want_sel)
            WANT_HEADER: want_next = HEADER_BYTES - off_inc;
            WANT_FRAME:
            begin
                // Past the end of the announced frame the count saturates at one.
                if (rec.frame_len > off_inc)
                begin
                    want_next = rec.frame_len - off_inc;
                end
                else
                begin
                    want_next = 17'd1;
                end
            end
            default:     want_next = 17'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rec_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            event_reg  <= rec.event_code;
            byte_reg   <= rec.data;
            offset_reg <= rec.offset;
            want_reg   <= want_next;
        end
    end

    assign result_valid = valid_reg;
    assign event_res    = event_reg;
    assign byte_out     = byte_reg;
    assign frame_offset = offset_reg;
    assign bytes_wanted = want_reg;

endmodule

// ===== sv/ubx_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// UBX frame parser core
// Deframes a UBX byte stream and reports one classified event per byte.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid/item_ready) takes one beat per received byte:
// mode 0 carries data_byte, mode 1 returns the parser to hunting for sync.
// Every accepted beat produces exactly one beat on the result channel
// (result_valid/result_ready): the event code, the byte, its offset in the
// frame and the number of bytes still needed to finish the header or, once
// the length is known, the frame. result_valid is registered: the front end
// classifies the byte in the accept cycle and writes it into the queue, and
// the back end moves it into the output register when that is empty or taken.
// Throughput is one byte per cycle while the queue has room.
// When the receiver stalls, the output register holds its beat and the
// queue (QUEUE_DEPTH entries) absorbs further bytes; item_ready drops only
// when the queue is full. Reset clears the parser to hunting, empties the
// queue and output, and sets max_frame_bytes to 256. The APB register at
// byte address 0 is max_frame_bytes; write it only while the block is idle.
// ----------------------------------------------------------------------------
module ubx_frame_parser_core #(
    parameter int QUEUE_DEPTH = ubxp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Item channel
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          mode,
    input  logic [7:0]                    data_byte,
    // Result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [2:0]                    event_res,
    output logic [7:0]                    byte_out,
    output logic [ubxp_pkg::OFFSET_W-1:0] frame_offset,
    output logic [ubxp_pkg::OFFSET_W-1:0] bytes_wanted
);
    import ubxp_pkg::*;

    logic [OFFSET_W-1:0] max_frame_reg;
    logic                reg_sel;
    logic                item_accept;
    logic                queue_full;
    logic                queue_not_empty;
    logic                queue_pop;
    rec_t                front_rec;
    rec_t                queue_rec;

    // Configuration: bit 2 of the byte address selects the register word.
    // The low two address bits pick a byte lane and are not decoded.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MAX_FRAME);
    assign prdata  = reg_sel ? {15'd0, max_frame_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            max_frame_reg <= pwdata[OFFSET_W-1:0];
        end
    end

    // The front end takes a byte whenever the queue has room.
    assign item_ready  = !queue_full;
    assign item_accept = item_valid && item_ready;

    ubxp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (item_accept),
        .mode      (mode),
        .data_byte (data_byte),
        .max_frame (max_frame_reg),
        .rec       (front_rec)
    );

    ubxp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_accept),
        .wr_rec    (front_rec),
        .pop       (queue_pop),
        .rd_rec    (queue_rec),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    ubxp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (queue_rec),
        .rec_valid    (queue_not_empty),
        .rec_pop      (queue_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .event_res    (event_res),
        .byte_out     (byte_out),
        .frame_offset (frame_offset),
        .bytes_wanted (bytes_wanted)
    );

    // Every terminal or non-frame event asks for exactly one more byte.
    a_terminal_want_one: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_res != EV_SYNC) && (event_res != EV_BODY)
        |-> (bytes_wanted == 17'd1))
        else $error("terminal event with bytes_wanted other than one");

    // A reset beat carries zero payload at frame offset zero.
    a_reset_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_res == EV_RESET)
        |-> (byte_out == 8'd0) && (frame_offset == '0))
        else $error("reset event with nonzero byte or offset");

    // Discarded bytes never sit inside a frame.
    a_discard_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_res == EV_DISCARD) |-> (frame_offset == '0))
        else $error("discarded byte with nonzero frame offset");

    // A completed frame is at least the minimum frame size long.
    a_frame_end_offset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((event_res == EV_OK) || (event_res == EV_BAD_CK))
        |-> (frame_offset >= 17'd7))
        else $error("frame end reported before the minimum frame size");

endmodule
